// File: rtl/core/lpl_pkg.sv
// ----------------------------------------------------------------------------
// Look-ahead peak limiter package
// Shared types, register indexes, style codes and the saturation table.
// ----------------------------------------------------------------------------
package lpl_pkg;

    localparam int unsigned MAX_DELAY_DEF = 2048;

    localparam logic [23:0] UNITY    = 24'h800000;
    localparam logic [23:0] UNITY_M1 = 24'h7FFFFF;

    // Register indexes on the configuration channel.
    localparam logic [7:0] CFG_INPUT_GAIN    = 8'd0;
    localparam logic [7:0] CFG_CEILING_LEVEL = 8'd1;
    localparam logic [7:0] CFG_OUTPUT_GAIN   = 8'd2;
    localparam logic [7:0] CFG_ATTACK_COEFF  = 8'd3;
    localparam logic [7:0] CFG_RELEASE_COEFF = 8'd4;
    localparam logic [7:0] CFG_STYLE_MODE    = 8'd5;
    localparam logic [7:0] CFG_LINK_CHANNELS = 8'd6;
    localparam logic [7:0] CFG_LOOKAHEAD     = 8'd7;

    // Style codes.
    localparam logic [2:0] STYLE_CLEAN  = 3'd0;
    localparam logic [2:0] STYLE_PUNCH  = 3'd1;
    localparam logic [2:0] STYLE_SMOOTH = 3'd2;
    localparam logic [2:0] STYLE_LOUD   = 3'd3;
    localparam logic [2:0] STYLE_ANALOG = 3'd4;
    localparam logic [2:0] STYLE_MASTER = 3'd5;

    // Reset values of the registers.
    localparam logic [23:0] RST_INPUT_GAIN    = 24'd262144;
    localparam logic [23:0] RST_CEILING_LEVEL = 24'd8292521;
    localparam logic [23:0] RST_OUTPUT_GAIN   = 24'd8388608;
    localparam logic [23:0] RST_ATTACK_COEFF  = 24'd16431281;
    localparam logic [23:0] RST_RELEASE_COEFF = 24'd16773720;
    localparam logic [2:0]  RST_STYLE_MODE    = 3'd0;
    localparam logic        RST_LINK_CHANNELS = 1'b1;
    localparam logic [10:0] RST_LOOKAHEAD     = 11'd240;

    // Knee factors: 1.08 and 1.15 as Q1.16, 0.12 and 0.05 as Q0.16.
    localparam logic [16:0] PUNCH_K  = 17'd70779;
    localparam logic [16:0] LOUD_K   = 17'd75366;
    localparam logic [12:0] ANALOG_K = 13'd7864;
    localparam logic [12:0] MASTER_K = 13'd3277;

    typedef struct packed {
        logic signed [23:0] left_sample;
        logic signed [23:0] right_sample;
    } t_in;

    typedef struct packed {
        logic signed [23:0] left_out;
        logic signed [23:0] right_out;
        logic [23:0]        left_gain;
        logic [23:0]        right_gain;
    } t_out;

    typedef struct packed {
        logic [7:0]  index;
        logic [23:0] data;
    } t_cfg;

    typedef struct packed {
        logic start;
        logic sqrt;
    } t_dv_ctl;

    // tanh(1.4x)/1.4 at x = 0..4 in steps of 1/4, Q0.23.
    function automatic logic [22:0] sat_tab(input logic [4:0] idx);
        logic [22:0] v;
        case (idx)
            5'd0:    v = 23'd0;
            5'd1:    v = 23'd2015516;
            5'd2:    v = 23'd3621289;
            5'd3:    v = 23'd4684468;
            5'd4:    v = 23'd5304908;
            5'd5:    v = 23'd5640593;
            5'd6:    v = 23'd5814815;
            5'd7:    v = 23'd5903285;
            5'd8:    v = 23'd5947712;
            5'd9:    v = 23'd5969897;
            5'd10:   v = 23'd5980945;
            5'd11:   v = 23'd5986439;
            5'd12:   v = 23'd5989169;
            5'd13:   v = 23'd5990525;
            5'd14:   v = 23'd5991198;
            5'd15:   v = 23'd5991533;
            default: v = 23'd5991699;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/lpl_chan_if.sv
// ----------------------------------------------------------------------------
// Look-ahead peak limiter channel
// Valid/ready channel that carries one item of payload type T.
// ----------------------------------------------------------------------------
interface lpl_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/lpl_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lpl_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 2048,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/core/lpl_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned 32 x 32 multiply with a registered 64-bit product.
// ----------------------------------------------------------------------------
module lpl_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);
    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;
endmodule

// File: rtl/core/lpl_divsqrt.sv
// ----------------------------------------------------------------------------
// Shared divide / square-root unit
// Restoring division or digit-by-digit square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module lpl_divsqrt
    import lpl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dv_ctl     i_ctl,
    input  logic [63:0] i_num,
    input  logic [45:0] i_den,
    output logic        o_done,
    output logic [23:0] o_q
);
    logic [63:0] r_rem;
    logic [69:0] r_sd;
    logic [47:0] r_q;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_sqrt;
    logic        r_done;

    logic [69:0] cmp;
    logic        ge;

    // For the square root the trial value is root plus the current bit.
    assign cmp = r_sqrt ? (70'(r_q) + r_sd) : r_sd;
    assign ge  = {6'b0, r_rem} >= cmp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_sqrt <= i_ctl.sqrt;
                r_rem  <= i_num;
                r_q    <= '0;
                r_cnt  <= 5'd23;
                r_sd   <= i_ctl.sqrt ? (70'(1) << 46) : {1'b0, i_den, 23'b0};
            end else if (r_busy) begin
                if (ge) begin
                    r_rem <= r_rem - cmp[63:0];
                end
                if (r_sqrt) begin
                    r_q  <= ge ? ((r_q >> 1) + r_sd[47:0]) : (r_q >> 1);
                    r_sd <= r_sd >> 2;
                end else begin
                    r_q  <= {r_q[46:0], ge};
                    r_sd <= r_sd >> 1;
                end
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q[23:0];
endmodule

// File: rtl/core/lookahead_peak_limiter_unit.sv
// ----------------------------------------------------------------------------
// Look-ahead peak limiter
// Stereo limiter: delay ring, style-shaped gain target, one-pole envelope,
// and output shaping, all sequenced over one multiplier and one divider.
// ----------------------------------------------------------------------------
// Per frame: read the delayed pair, then per channel gain target, envelope and
// output shaping, with an interpolation step in analog style when the scaled
// sample lies below the end of the table. A channel that needs gain reduction
// runs the 24-step divide, after a knee step in punch, loud, analog and master
// styles, and twice (divide, square root) in smooth. One frame is in flight; the
// next waits while the output register is full. Reset is synchronous and needs no clearing pass.
module lookahead_peak_limiter_unit
    import lpl_pkg::*;
#(
    parameter int unsigned MAX_DELAY = MAX_DELAY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lpl_chan_if.sink   i_in,
    lpl_chan_if.sink   i_cfg,
    lpl_chan_if.source o_out
);
    localparam int unsigned AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int unsigned CW = (AW > 11) ? AW : 11;
    localparam logic [CW-1:0] DMAX    = CW'(MAX_DELAY - 1);
    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(MAX_DELAY);
    localparam logic [AW-1:0] WP_LAST = AW'(MAX_DELAY - 1);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_RD   = 5'd1;
    localparam logic [4:0] S_CAP  = 5'd2;
    localparam logic [4:0] S_A    = 5'd3;
    localparam logic [4:0] S_A2   = 5'd4;
    localparam logic [4:0] S_PK   = 5'd5;
    localparam logic [4:0] S_AN   = 5'd6;
    localparam logic [4:0] S_DIV  = 5'd7;
    localparam logic [4:0] S_SQ   = 5'd8;
    localparam logic [4:0] S_ENV1 = 5'd9;
    localparam logic [4:0] S_ENV2 = 5'd10;
    localparam logic [4:0] S_ENV3 = 5'd11;
    localparam logic [4:0] S_M1   = 5'd12;
    localparam logic [4:0] S_M2   = 5'd13;
    localparam logic [4:0] S_M3   = 5'd14;
    localparam logic [4:0] S_M4   = 5'd15;
    localparam logic [4:0] S_M5   = 5'd16;
    localparam logic [4:0] S_DONE = 5'd17;

    // Configuration registers.
    logic [23:0] r_ig, r_ceil, r_og, r_att, r_rel;
    logic [2:0]  r_style;
    logic        r_link;
    logic [10:0] r_dly;

    logic [4:0]  r_state;
    logic        r_ch;
    logic [AW-1:0] r_wp;
    logic        r_full;
    logic        r_rdok;
    logic [23:0] r_pl, r_pr;
    logic signed [23:0] r_dl, r_dr;
    logic [28:0] r_a;
    logic [23:0] r_t;
    logic [23:0] r_env [2];
    logic [23:0] r_eg  [2];
    logic [47:0] r_p1;
    logic [22:0] r_lo;
    logic [23:0] r_y   [2];
    t_out        r_out;
    logic        r_ovalid;

    // Ring address arithmetic.
    logic [CW-1:0] dly_c;
    logic [AW-1:0] dly_a;
    logic [AW:0]   rp_sum;
    logic [AW-1:0] rp;
    logic          rd_ok;

    assign dly_c  = (CW'(r_dly) > DMAX) ? DMAX : CW'(r_dly);
    assign dly_a  = dly_c[AW-1:0];
    assign rp_sum = (r_wp >= dly_a) ? ({1'b0, r_wp} - {1'b0, dly_a})
                                    : ({1'b0, r_wp} + DEPTH_W - {1'b0, dly_a});
    assign rp     = rp_sum[AW-1:0];
    // An entry not yet written since reset reads as zero.
    assign rd_ok  = r_full || (r_wp >= dly_a);

    logic in_acc;
    logic [47:0] ram_rdata;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_acc      = i_in.valid && i_in.ready;

    lpl_ram #(
        .WIDTH (48),
        .DEPTH (MAX_DELAY),
        .AW    (AW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_wp),
        .i_wdata ({i_in.data.left_sample, i_in.data.right_sample}),
        .i_re    (r_state == S_RD),
        .i_raddr (rp),
        .o_rdata (ram_rdata)
    );

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;

    lpl_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    t_dv_ctl     dv_ctl;
    logic [63:0] dv_num;
    logic [45:0] dv_den;
    logic        dv_done;
    logic [23:0] dv_q;

    lpl_divsqrt u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (dv_ctl),
        .i_num   (dv_num),
        .i_den   (dv_den),
        .o_done  (dv_done),
        .o_q     (dv_q)
    );

    // Shared datapath values.
    logic        env_idx;
    logic [23:0] env_cur;
    logic [23:0] k_sel;
    logic [24:0] k_cmp;
    logic [23:0] peak;
    logic [28:0] a_new;
    logic        a_over;
    logic [29:0] knee;
    logic signed [23:0] d_sel;
    logic [23:0] d_mag;
    logic [28:0] m0, m1;
    logic [3:0]  tidx;
    logic [22:0] t_lo, t_hi;
    logic [23:0] m_int;
    logic [29:0] m2;
    logic [23:0] m_clip;
    logic [23:0] y_val;
    logic [48:0] env_sum;
    logic [23:0] q_sat;

    assign env_idx = r_link ? 1'b0 : r_ch;
    assign env_cur = r_env[env_idx];
    assign k_sel   = (r_t < env_cur) ? r_att : r_rel;
    assign k_cmp   = 25'h1000000 - {1'b0, k_sel};
    assign peak    = r_link ? ((r_pl > r_pr) ? r_pl : r_pr) : (r_ch ? r_pr : r_pl);
    assign a_new   = prod[46:18];
    assign a_over  = a_new > {5'b0, r_ceil};
    assign knee    = {6'b0, r_ceil} + 30'(prod[41:16]);
    assign d_sel   = r_ch ? r_dr : r_dl;
    assign d_mag   = d_sel[23] ? (24'd0 - d_sel) : d_sel;
    assign m0      = prod[46:18];
    assign m1      = prod[51:23];
    assign tidx    = m1[24:21];
    assign t_lo    = sat_tab({1'b0, tidx});
    assign t_hi    = sat_tab(5'({1'b0, tidx}) + 5'd1);
    assign m_int   = {1'b0, r_lo} + 24'(prod[41:21]);
    assign m2      = prod[52:23];
    assign m_clip  = (m2 > {6'b0, r_ceil}) ? r_ceil : m2[23:0];
    assign y_val   = d_sel[23] ? (24'd0 - ((m_clip > UNITY) ? UNITY : m_clip))
                               : ((m_clip > UNITY_M1) ? UNITY_M1 : m_clip);
    assign env_sum = {1'b0, r_p1} + prod[48:0] + 49'h800000;
    assign q_sat   = (dv_q > UNITY) ? UNITY : dv_q;

    // Multiplier operands, divider requests.
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        dv_ctl = '0;
        dv_num = {40'b0, r_ceil} << 23;
        dv_den = {17'b0, r_a};
        case (r_state)
            S_A: begin
                mul_a = {8'b0, peak};
                mul_b = {8'b0, r_ig};
            end
            S_A2: begin
                if (a_over) begin
                    if (r_style == STYLE_PUNCH || r_style == STYLE_LOUD) begin
                        mul_a = {3'b0, a_new};
                        mul_b = (r_style == STYLE_PUNCH) ? {15'b0, PUNCH_K}
                                                         : {15'b0, LOUD_K};
                    end else if (r_style == STYLE_ANALOG || r_style == STYLE_MASTER) begin
                        mul_a = {3'b0, a_new - {5'b0, r_ceil}};
                        mul_b = (r_style == STYLE_ANALOG) ? {19'b0, ANALOG_K}
                                                          : {19'b0, MASTER_K};
                    end else begin
                        dv_ctl.start = 1'b1;
                        dv_den       = {17'b0, a_new};
                    end
                end
            end
            S_PK: begin
                dv_ctl.start = 1'b1;
                dv_num       = {1'b0, r_ceil, 39'b0};
                dv_den       = prod[45:0];
            end
            S_AN: begin
                dv_ctl.start = 1'b1;
                dv_num       = {11'b0, knee[29:0], 23'b0};
            end
            S_DIV: begin
                if (dv_done && r_style == STYLE_SMOOTH) begin
                    dv_ctl.start = 1'b1;
                    dv_ctl.sqrt  = 1'b1;
                    dv_num       = {17'b0, dv_q, 23'b0};
                end
            end
            S_ENV1: begin
                mul_a = {8'b0, k_sel};
                mul_b = {8'b0, env_cur};
            end
            S_ENV2: begin
                mul_a = {7'b0, k_cmp};
                mul_b = {8'b0, r_t};
            end
            S_M1: begin
                mul_a = {8'b0, d_mag};
                mul_b = {8'b0, r_ig};
            end
            S_M2: begin
                mul_a = {3'b0, m0};
                mul_b = {8'b0, r_eg[r_ch]};
            end
            S_M3: begin
                if (r_style == STYLE_ANALOG) begin
                    if (m1[28:25] != 4'd0) begin
                        mul_a = {9'b0, sat_tab(5'd16)};
                        mul_b = {8'b0, r_og};
                    end else begin
                        mul_a = {9'b0, t_hi - t_lo};
                        mul_b = {11'b0, m1[20:0]};
                    end
                end else begin
                    mul_a = {3'b0, m1};
                    mul_b = {8'b0, r_og};
                end
            end
            S_M4: begin
                mul_a = {8'b0, m_int};
                mul_b = {8'b0, r_og};
            end
            default: begin
            end
        endcase
        // a is held in r_a by the time the knee states run.
        if (r_state == S_AN) begin
            dv_den = {17'b0, r_a};
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ig    <= RST_INPUT_GAIN;
            r_ceil  <= RST_CEILING_LEVEL;
            r_og    <= RST_OUTPUT_GAIN;
            r_att   <= RST_ATTACK_COEFF;
            r_rel   <= RST_RELEASE_COEFF;
            r_style <= RST_STYLE_MODE;
            r_link  <= RST_LINK_CHANNELS;
            r_dly   <= RST_LOOKAHEAD;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.data.index)
                CFG_INPUT_GAIN:    r_ig    <= i_cfg.data.data;
                CFG_CEILING_LEVEL: r_ceil  <= i_cfg.data.data;
                CFG_OUTPUT_GAIN:   r_og    <= i_cfg.data.data;
                CFG_ATTACK_COEFF:  r_att   <= i_cfg.data.data;
                CFG_RELEASE_COEFF: r_rel   <= i_cfg.data.data;
                CFG_STYLE_MODE:    r_style <= i_cfg.data.data[2:0];
                CFG_LINK_CHANNELS: r_link  <= i_cfg.data.data[0];
                CFG_LOOKAHEAD:     r_dly   <= i_cfg.data.data[10:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ch     <= 1'b0;
            r_wp     <= '0;
            r_full   <= 1'b0;
            r_env[0] <= UNITY;
            r_env[1] <= UNITY;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_DONE && (!r_ovalid || o_out.ready)) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_pl    <= i_in.data.left_sample[23]
                                   ? 24'd0 - i_in.data.left_sample : i_in.data.left_sample;
                        r_pr    <= i_in.data.right_sample[23]
                                   ? 24'd0 - i_in.data.right_sample : i_in.data.right_sample;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_rdok <= rd_ok;
                    if (r_wp == WP_LAST) begin
                        r_wp   <= '0;
                        r_full <= 1'b1;
                    end else begin
                        r_wp <= r_wp + AW'(1);
                    end
                    r_ch    <= 1'b0;
                    r_state <= S_CAP;
                end
                S_CAP: begin
                    r_dl    <= r_rdok ? ram_rdata[47:24] : 24'sd0;
                    r_dr    <= r_rdok ? ram_rdata[23:0]  : 24'sd0;
                    r_state <= S_A;
                end
                S_A: begin
                    r_state <= S_A2;
                end
                S_A2: begin
                    r_a <= a_new;
                    if (!a_over) begin
                        r_t     <= UNITY;
                        r_state <= S_ENV1;
                    end else if (r_style == STYLE_PUNCH || r_style == STYLE_LOUD) begin
                        r_state <= S_PK;
                    end else if (r_style == STYLE_ANALOG || r_style == STYLE_MASTER) begin
                        r_state <= S_AN;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_PK, S_AN: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (dv_done) begin
                        if (r_style == STYLE_SMOOTH) begin
                            r_state <= S_SQ;
                        end else begin
                            r_t     <= q_sat;
                            r_state <= S_ENV1;
                        end
                    end
                end
                S_SQ: begin
                    if (dv_done) begin
                        r_t     <= q_sat;
                        r_state <= S_ENV1;
                    end
                end
                S_ENV1: begin
                    r_state <= S_ENV2;
                end
                S_ENV2: begin
                    r_p1    <= prod[47:0];
                    r_state <= S_ENV3;
                end
                S_ENV3: begin
                    r_env[env_idx] <= env_sum[47:24];
                    r_eg[r_ch]     <= env_sum[47:24];
                    r_state        <= S_M1;
                end
                S_M1: begin
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_lo <= t_lo;
                    if (r_style == STYLE_ANALOG && m1[28:25] == 4'd0) begin
                        r_state <= S_M4;
                    end else begin
                        r_state <= S_M5;
                    end
                end
                S_M4: begin
                    r_state <= S_M5;
                end
                S_M5: begin
                    r_y[r_ch] <= y_val;
                    if (r_ch) begin
                        r_state <= S_DONE;
                    end else begin
                        r_ch    <= 1'b1;
                        r_state <= S_A;
                    end
                end
                S_DONE: begin
                    // The item waits here while an earlier result is still held.
                    if (!r_ovalid || o_out.ready) begin
                        r_out.left_out   <= r_y[0];
                        r_out.right_out  <= r_y[1];
                        r_out.left_gain  <= r_eg[0];
                        r_out.right_gain <= r_eg[1];
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;

`ifndef NO_ASSERTIONS
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_done |-> (r_state == S_DIV || r_state == S_SQ))
        else $error("divider finished outside a wait state");

    a_env_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_env[0] <= UNITY) && (r_env[1] <= UNITY))
        else $error("envelope above unity");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_RD))
        else $error("accepted item did not start the sequence");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_ovalid) |=> (r_ovalid && r_state == S_IDLE))
        else $error("finished item was not moved to the output register");
`endif

endmodule
